FILE: hw/rtl/b64d_pkg.sv
// Shared types, character codes and the alphabet lookup for the base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int unsigned MaxResults = 4;
    localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

    localparam logic [7:0] ChUpperA = 8'h41;
    localparam logic [7:0] ChUpperZ = 8'h5A;
    localparam logic [7:0] ChLowerA = 8'h61;
    localparam logic [7:0] ChLowerZ = 8'h7A;
    localparam logic [7:0] ChDigit0 = 8'h30;
    localparam logic [7:0] ChDigit9 = 8'h39;
    localparam logic [7:0] ChPlus   = 8'h2B;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChPad    = 8'h3D;

    localparam logic [7:0] LowerOff = 8'd71;  // 'a' maps to 26
    localparam logic [7:0] DigitOff = 8'd4;   // '0' maps to 52
    localparam logic [5:0] SxPlus   = 6'd62;
    localparam logic [5:0] SxSlash  = 6'd63;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_result;

    typedef struct packed {
        logic [ResCntW-1:0]          count;
        t_result [MaxResults-1:0]    res;   // res[0] goes out first
    } t_group;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet    s;
        logic [7:0] t;
        s = '{ok: 1'b0, value: 6'd0};
        t = 8'd0;
        if (c >= ChUpperA && c <= ChUpperZ) begin
            t = c - ChUpperA;
            s = '{ok: 1'b1, value: t[5:0]};
        end else if (c >= ChLowerA && c <= ChLowerZ) begin
            t = c - LowerOff;
            s = '{ok: 1'b1, value: t[5:0]};
        end else if (c >= ChDigit0 && c <= ChDigit9) begin
            t = c + DigitOff;
            s = '{ok: 1'b1, value: t[5:0]};
        end else if (c == ChPlus) begin
            s = '{ok: 1'b1, value: SxPlus};
        end else if (c == ChSlash) begin
            s = '{ok: 1'b1, value: SxSlash};
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/b64d_group.sv
// Sextet gathering state and the decode of one character into its group of results.
`timescale 1ns / 1ps

module b64d_group
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output t_group     o_group
);

    logic [17:0] r_store, n_store;
    logic [1:0]  r_count, n_count;
    logic        r_stopped, n_stopped;

    t_sextet     sx;
    logic        sx_ok;
    logic        flush;
    logic [17:0] fl_store;
    logic [1:0]  fl_count;
    logic [23:0] fl_bits;
    logic [23:0] full_bits;
    t_group      grp;

    assign sx    = sextet_of(i_char);
    assign sx_ok = sx.ok && (i_char != ChPad);
    assign full_bits = {r_store, sx.value};

    always_comb begin
        grp       = '0;
        n_store   = r_store;
        n_count   = r_count;
        n_stopped = r_stopped;
        flush     = 1'b0;
        fl_store  = r_store;
        fl_count  = r_count;

        if (r_stopped) begin
            if (i_last) begin
                n_stopped = 1'b0;
            end
        end else if (!sx_ok) begin
            // stop: flush what is pending, then ignore until the last character
            flush     = 1'b1;
            n_stopped = !i_last;
            n_store   = '0;
            n_count   = '0;
        end else if (r_count == 2'd3) begin
            grp.res[0] = '{data_byte: full_bits[23:16], has_byte: 1'b1, end_of_message: 1'b0};
            grp.res[1] = '{data_byte: full_bits[15:8],  has_byte: 1'b1, end_of_message: 1'b0};
            grp.res[2] = '{data_byte: full_bits[7:0],   has_byte: 1'b1, end_of_message: 1'b0};
            grp.count  = ResCntW'(3);
            n_store    = '0;
            n_count    = '0;
            flush      = i_last;
            fl_store   = '0;
            fl_count   = '0;
        end else begin
            n_store  = {r_store[11:0], sx.value};
            n_count  = r_count + 2'd1;
            flush    = i_last;
            fl_store = n_store;
            fl_count = n_count;
            if (i_last) begin
                n_store = '0;
                n_count = '0;
            end
        end

        // align the pending sextets to the top of a 24-bit group
        case (fl_count)
            2'd2:    fl_bits = {fl_store[11:0], 12'd0};
            2'd3:    fl_bits = {fl_store, 6'd0};
            default: fl_bits = '0;
        endcase

        if (flush) begin
            case (fl_count)
                2'd2: begin
                    grp.res[0] = '{data_byte: fl_bits[23:16], has_byte: 1'b1,
                                   end_of_message: 1'b0};
                    grp.res[1] = '{data_byte: 8'd0, has_byte: 1'b0, end_of_message: 1'b1};
                    grp.count  = ResCntW'(2);
                end
                2'd3: begin
                    grp.res[0] = '{data_byte: fl_bits[23:16], has_byte: 1'b1,
                                   end_of_message: 1'b0};
                    grp.res[1] = '{data_byte: fl_bits[15:8], has_byte: 1'b1,
                                   end_of_message: 1'b0};
                    grp.res[2] = '{data_byte: 8'd0, has_byte: 1'b0, end_of_message: 1'b1};
                    grp.count  = ResCntW'(3);
                end
                default: begin
                    // append the end result after any full group already placed
                    grp.res[grp.count[1:0]] = '{data_byte: 8'd0, has_byte: 1'b0,
                                                end_of_message: 1'b1};
                    grp.count = grp.count + ResCntW'(1);
                end
            endcase
        end
    end

    assign o_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store   <= '0;
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else if (i_take) begin
            r_store   <= n_store;
            r_count   <= n_count;
            r_stopped <= n_stopped;
        end
    end

`ifndef SYNTH
    a_stop_clears_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_count == 2'd0 && r_store == 18'd0))
        else $error("group not cleared while stopped");

    a_last_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last) |=> (r_count == 2'd0 && !r_stopped))
        else $error("state left after last character");

    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (o_group.count == '0))
        else $error("results produced while stopped");
`endif

endmodule

FILE: hw/rtl/b64d_burst.sv
// Result register for one group of results, sent one per cycle while not stalled.
`timescale 1ns / 1ps

module b64d_burst
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_group     i_group,
    output logic       o_can_load,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_result
);

    t_result [MaxResults-1:0] r_buf;
    logic [ResCntW-1:0]       r_left;
    logic [1:0]               r_idx;
    logic                     fire;

    assign o_valid    = (r_left != '0);
    assign fire       = o_valid && !i_stall;
    assign o_can_load = (r_left == '0) || (r_left == ResCntW'(1) && fire);
    assign o_result   = r_buf[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_left <= i_group.count;
            r_idx  <= '0;
        end else if (fire) begin
            r_left <= r_left - ResCntW'(1);
            r_idx  <= r_idx + 2'd1;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_group.res;
        end
    end

`ifndef SYNTH
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= ResCntW'(MaxResults))
        else $error("result count beyond group size");

    a_eom_closes_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.end_of_message) |-> (r_left == ResCntW'(1)))
        else $error("end of message not the final result of its group");

    a_no_byte_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.has_byte) |-> (o_result.data_byte == 8'd0))
        else $error("empty result carries a byte");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("group loaded over pending results");
`endif

endmodule

FILE: hw/rtl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: input register, group decode and result register.
`timescale 1ns / 1ps

// Decodes standard-alphabet base64 text, one character per item, into bytes. A character
// is taken into an input register, decoded against the sextet state once the result
// register can load, and its results (0 to 4) are placed in that register, which sends
// one result per cycle while the receiver does not stall. Characters that yield at most
// one result flow at one item per cycle without receiver stalls; one with more results
// holds the output port until all are out, the port alone setting throughput (on average
// four characters give three bytes). '=' or any character outside the alphabet ends the
// message: the partial group is flushed and an end-of-message result follows; further
// characters are dropped without results until the one flagged last, which clears the
// block. The closing result of every message has o_end_of_message set and carries no byte.
module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_encoded_char,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic       o_has_byte,
    output logic       o_end_of_message
);

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       can_load;
    logic       take;
    t_group     group;
    t_result    result;

    assign take    = r_in_valid && can_load;
    assign o_stall = r_in_valid && !can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_char <= i_encoded_char;
            r_last <= i_last_char;
        end
    end

    b64d_group u_group (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_char  (r_char),
        .i_last  (r_last),
        .o_group (group)
    );

    b64d_burst u_burst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_group    (group),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (result)
    );

    assign o_data_byte      = result.data_byte;
    assign o_has_byte       = result.has_byte;
    assign o_end_of_message = result.end_of_message;

endmodule

FILE: dv/b64d_decode_monitor.sv
// Watches both channels of the base64 stream decoder, predicts each result item and compares.
`timescale 1ns / 1ps

module b64d_decode_monitor
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_char,
    input  logic       i_last,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_has_byte,
    input  logic       i_eom,
    output int         o_fail_count,
    output int         o_pending
);

    logic [17:0] grp_bits;
    logic [1:0]  grp_len;
    logic        halted;
    t_result     due_q[$];
    int          n_fail;

    assign o_fail_count = n_fail;

    // {ok, value} for one character of the standard alphabet
    function automatic logic [6:0] char_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= ChUpperA && c <= ChUpperZ) begin
            t = c - ChUpperA;
            return {1'b1, t[5:0]};
        end
        if (c >= ChLowerA && c <= ChLowerZ) begin
            t = c - ChLowerA + 8'd26;
            return {1'b1, t[5:0]};
        end
        if (c >= ChDigit0 && c <= ChDigit9) begin
            t = c - ChDigit0 + 8'd52;
            return {1'b1, t[5:0]};
        end
        if (c == ChPlus) return {1'b1, SxPlus};
        if (c == ChSlash) return {1'b1, SxSlash};
        return 7'd0;
    endfunction

    task automatic push_result(input logic [7:0] b, input logic has, input logic eom);
        due_q.push_back('{data_byte: b, has_byte: has, end_of_message: eom});
    endtask

    // Flush the partial group, then the closing item
    task automatic close_message();
        logic [23:0] g;
        int          n;
        int          b;
        n = int'(grp_len);
        if (n > 0) begin
            g = {6'd0, grp_bits} << (6 * (4 - n));
            for (b = 0; b < n - 1; b++)
                push_result(g[23 - 8 * b -: 8], 1'b1, 1'b0);
        end
        push_result(8'd0, 1'b0, 1'b1);
        grp_bits = 18'd0;
        grp_len  = 2'd0;
    endtask

    task automatic decode_char(input logic [7:0] c, input logic last);
        logic [6:0]  sx;
        logic [23:0] g;
        if (halted) begin
            if (last) begin
                halted   = 1'b0;
                grp_bits = 18'd0;
                grp_len  = 2'd0;
            end
            return;
        end
        sx = char_value(c);
        if (c == ChPad || !sx[6]) begin
            close_message();
            halted = !last;
            return;
        end
        if (grp_len == 2'd3) begin
            g = {grp_bits, sx[5:0]};
            push_result(g[23:16], 1'b1, 1'b0);
            push_result(g[15:8], 1'b1, 1'b0);
            push_result(g[7:0], 1'b1, 1'b0);
            grp_bits = 18'd0;
            grp_len  = 2'd0;
        end else begin
            grp_bits = {grp_bits[11:0], sx[5:0]};
            grp_len  = grp_len + 2'd1;
        end
        if (last) close_message();
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            grp_bits = 18'd0;
            grp_len  = 2'd0;
            halted   = 1'b0;
            due_q.delete();
            n_fail   = 0;
        end else begin
            if (i_in_valid && !i_in_stall) decode_char(i_char, i_last);
            if (i_out_valid && !i_out_stall) begin
                got = '{data_byte: i_data_byte, has_byte: i_has_byte, end_of_message: i_eom};
                if (due_q.size() == 0) begin
                    if (n_fail < 10)
                        $display("%0t: unexpected item byte=%02h has=%0b eom=%0b",
                                 $realtime, got.data_byte, got.has_byte, got.end_of_message);
                    n_fail = n_fail + 1;
                end else begin
                    want = due_q.pop_front();
                    if (got !== want) begin
                        if (n_fail < 10)
                            $display({"%0t: expected byte=%02h has=%0b eom=%0b, ",
                                      "got byte=%02h has=%0b eom=%0b"},
                                     $realtime, want.data_byte, want.has_byte,
                                     want.end_of_message, got.data_byte, got.has_byte,
                                     got.end_of_message);
                        n_fail = n_fail + 1;
                    end
                end
            end
        end
        o_pending <= due_q.size();
    end

endmodule

FILE: dv/base64_stream_decoder_tb.sv
// Testbench top for the base64 stream decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module base64_stream_decoder_tb;
    import b64d_pkg::*;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic [7:0] i_encoded_char = 8'd0;
    logic       i_last_char    = 1'b0;
    logic       i_stall        = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_data_byte;
    logic       o_has_byte;
    logic       o_end_of_message;

    int fail_count;
    int pending;
    bit quiet    = 1'b0;
    int hold_cnt = 0;
    int n_sent   = 0;

    always #4 i_clk = ~i_clk;

    base64_stream_decoder u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_encoded_char   (i_encoded_char),
        .i_last_char      (i_last_char),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_data_byte      (o_data_byte),
        .o_has_byte       (o_has_byte),
        .o_end_of_message (o_end_of_message)
    );

    b64d_decode_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_char       (i_encoded_char),
        .i_last       (i_last_char),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_data_byte  (o_data_byte),
        .i_has_byte   (o_has_byte),
        .i_eom        (o_end_of_message),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver back-pressure in random bursts
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall  <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_cnt <= $urandom_range(0, 17);
            i_stall  <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 6'd26) return ChUpperA + {2'b00, v};
        if (v < 6'd52) return ChLowerA + {2'b00, v - 6'd26};
        if (v < 6'd62) return ChDigit0 + {2'b00, v - 6'd52};
        if (v == SxPlus) return ChPlus;
        return ChSlash;
    endfunction

    // Offer one item and hold it until it is taken
    task automatic send_char(input logic [7:0] c, input logic last);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_encoded_char <= c;
        i_last_char    <= last;
        do @(posedge i_clk); while (o_stall);
        n_sent = n_sent + 1;
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // Pause the sender until every predicted item has come out
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic random_message();
        int         len;
        int         stop_at;
        int         k;
        logic [7:0] c;
        len     = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
        stop_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
        for (k = 0; k < len; k++) begin
            if (k == stop_at) begin
                c = ($urandom_range(0, 1) == 0) ? ChPad : 8'($urandom_range(0, 255));
            end else if (stop_at >= 0 && k > stop_at) begin
                // noise after the stop
                c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                : b64_char(6'($urandom_range(0, 63)));
            end else if ($urandom_range(0, 19) == 0) begin
                c = 8'($urandom_range(0, 255));
            end else begin
                c = b64_char(6'($urandom_range(0, 63)));
            end
            if (n_sent >= 140) quiet = 1'b1;
            send_char(c, k == len - 1);
        end
    endtask

    initial begin
        bit drained_mid;
        drained_mid = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of the alphabet, full group closed by the last item
        send_text("AZaz09+/", 1'b1);
        send_text("Q", 1'b1);
        send_text("QUI", 1'b1);
        // pad stops, the trailing pad is dropped
        send_text("QQ==", 1'b1);
        send_char(8'h00, 1'b1);
        // stop on an invalid byte, then drop until the last item
        send_text("AB", 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("xy", 1'b1);
        send_text("ab=", 1'b1);
        drain();

        while (n_sent < 170) begin
            random_message();
            if (!drained_mid && n_sent >= 85) begin
                drain();
                drained_mid = 1'b1;
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: base64_stream_decoder.f
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_group.sv
hw/rtl/b64d_burst.sv
hw/rtl/base64_stream_decoder.sv
dv/b64d_decode_monitor.sv
dv/base64_stream_decoder_tb.sv
